@@ hdl/mwm_pkg.sv @@
`default_nettype none

package mwm_pkg;

    // Default edge length of the maze, in cells.
    localparam int MAZE_DIM_DEF = 16;

    // Number of absolute directions around a cell.
    localparam int NUM_DIRS = 4;

    // Commands carried by an input item.
    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_BLOCK  = 2'd2,
        CMD_CLEAR  = 2'd3
    } command_t;

    // Absolute directions, clockwise from north.
    typedef enum logic [1:0] {
        DIR_NORTH = 2'd0,
        DIR_EAST  = 2'd1,
        DIR_SOUTH = 2'd2,
        DIR_WEST  = 2'd3
    } dir_t;

    // One input item.
    typedef struct packed {
        logic [1:0] command;
        logic [3:0] pos_x;
        logic [3:0] pos_y;
        logic [1:0] heading;
        logic       sensed_left;
        logic       sensed_front;
        logic       sensed_right;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic wall_left;
        logic wall_ahead;
        logic wall_right_side;
    } out_item_t;

    // Update and read control for the wall store, indexed by absolute direction.
    typedef struct packed {
        logic                clear;
        logic [NUM_DIRS-1:0] we;
        logic [NUM_DIRS-1:0] val;
        dir_t                left_dir;
        dir_t                front_dir;
        dir_t                right_dir;
    } wall_ctl_t;

endpackage

`default_nettype wire

@@ hdl/mwm_stream_if.sv @@
`default_nettype none

// Valid/ready channel carrying one item per handshake.
interface mwm_stream_if #(
    parameter type item_t = logic
) ();

    logic  valid;
    logic  ready;
    item_t item;

    modport source (
        output valid,
        output item,
        input  ready
    );

    modport sink (
        input  valid,
        input  item,
        output ready
    );

endinterface

`default_nettype wire

@@ hdl/mwm_decode.sv @@
`default_nettype none

module mwm_decode
    import mwm_pkg::*;
#(
    parameter int MAZE_DIM = MAZE_DIM_DEF
) (
    input  in_item_t                       item,
    output wall_ctl_t                      ctl,
    output logic [$clog2(MAZE_DIM)-1:0]    pos_x,
    output logic [$clog2(MAZE_DIM)-1:0]    pos_y
);

    localparam int XW = $clog2(MAZE_DIM);
    localparam int EW = (XW > 4) ? XW : 4;
    localparam logic [EW-1:0] MAX_EXT = EW'(MAZE_DIM - 1);
    localparam logic [XW-1:0] MAX_POS = XW'(MAZE_DIM - 1);

    logic [EW-1:0] x_ext;
    logic [EW-1:0] y_ext;
    logic [1:0]    left_code;
    logic [1:0]    right_code;
    logic [1:0]    back_code;

    // Coordinates past the far edge saturate to the last cell.
    assign x_ext = EW'(item.pos_x);
    assign y_ext = EW'(item.pos_y);
    assign pos_x = (x_ext > MAX_EXT) ? MAX_POS : XW'(x_ext);
    assign pos_y = (y_ext > MAX_EXT) ? MAX_POS : XW'(y_ext);

    // Turn the heading into the absolute directions of each side.
    assign left_code  = item.heading + 2'd3;
    assign right_code = item.heading + 2'd1;
    assign back_code  = item.heading + 2'd2;

    // Per-direction write enables and values for the command.
    always_comb
    begin
        ctl           = '0;
        ctl.left_dir  = dir_t'(left_code);
        ctl.front_dir = dir_t'(item.heading);
        ctl.right_dir = dir_t'(right_code);
        case (command_t'(item.command))
            CMD_RECORD:
            begin
                for (int unsigned d = 0; d < NUM_DIRS; d++)
                begin
                    ctl.we[d]  = (2'(d) != back_code);
                    ctl.val[d] = (2'(d) == left_code)    ? item.sensed_left :
                                 (2'(d) == item.heading) ? item.sensed_front :
                                                           item.sensed_right;
                end
            end
            CMD_BLOCK:
            begin
                ctl.we  = '1;
                ctl.val = '1;
            end
            CMD_CLEAR:
            begin
                ctl.clear = 1'b1;
            end
            default:
            begin
                ctl.we = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/mwm_wall_store.sv @@
`default_nettype none

module mwm_wall_store
    import mwm_pkg::*;
#(
    parameter int MAZE_DIM = MAZE_DIM_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  wall_ctl_t                   ctl,
    input  logic [$clog2(MAZE_DIM)-1:0] pos_x,
    input  logic [$clog2(MAZE_DIM)-1:0] pos_y,
    output out_item_t                   result
);

    localparam int XW = $clog2(MAZE_DIM);
    localparam int RW = $clog2(MAZE_DIM - 1);
    localparam logic [XW-1:0] MAX_POS = XW'(MAZE_DIM - 1);

    // horiz: word r bit c is the wall between cells (c, r) and (c, r+1).
    // vert:  word c bit r is the wall between cells (c, r) and (c+1, r).
    logic [MAZE_DIM-1:0] horiz_reg  [MAZE_DIM-1];
    logic [MAZE_DIM-1:0] horiz_next [MAZE_DIM-1];
    logic [MAZE_DIM-1:0] vert_reg   [MAZE_DIM-1];
    logic [MAZE_DIM-1:0] vert_next  [MAZE_DIM-1];
    logic [XW-1:0]       x_west;
    logic [XW-1:0]       y_south;
    logic [NUM_DIRS-1:0] abs_wall;

    // Each wall bit watches the two cells it separates.
    for (genvar w = 0; w < MAZE_DIM - 1; w++)
    begin : g_word
        for (genvar b = 0; b < MAZE_DIM; b++)
        begin : g_bit
            logic h_hit_n;
            logic h_hit_s;
            logic v_hit_e;
            logic v_hit_w;

            assign h_hit_n = (pos_x == XW'(b)) && (pos_y == XW'(w));
            assign h_hit_s = (pos_x == XW'(b)) && (pos_y == XW'(w + 1));
            assign v_hit_e = (pos_x == XW'(w)) && (pos_y == XW'(b));
            assign v_hit_w = (pos_x == XW'(w + 1)) && (pos_y == XW'(b));

            assign horiz_next[w][b] =
                ctl.clear                          ? 1'b0 :
                (h_hit_n && ctl.we[DIR_NORTH])     ? ctl.val[DIR_NORTH] :
                (h_hit_s && ctl.we[DIR_SOUTH])     ? ctl.val[DIR_SOUTH] :
                                                     horiz_reg[w][b];

            // Clearing keeps only the wall east of the start cell.
            assign vert_next[w][b] =
                ctl.clear                          ? ((w == 0 && b == 0) ? 1'b1 : 1'b0) :
                (v_hit_e && ctl.we[DIR_EAST])      ? ctl.val[DIR_EAST] :
                (v_hit_w && ctl.we[DIR_WEST])      ? ctl.val[DIR_WEST] :
                                                     vert_reg[w][b];
        end
    end

    // Map update; reset leaves the start cell's east wall in place.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAZE_DIM - 1; i++)
            begin
                horiz_reg[i] <= '0;
                vert_reg[i]  <= (i == 0) ? MAZE_DIM'(1) : '0;
            end
        end
        else if (wr_en)
        begin
            horiz_reg <= horiz_next;
            vert_reg  <= vert_next;
        end
    end

    // Read the four walls of the cell after the update; the border reads as wall.
    assign x_west  = pos_x - XW'(1);
    assign y_south = pos_y - XW'(1);

    assign abs_wall[DIR_NORTH] = (pos_y == MAX_POS) ? 1'b1 :
                                 horiz_next[pos_y[RW-1:0]][pos_x];
    assign abs_wall[DIR_EAST]  = (pos_x == MAX_POS) ? 1'b1 :
                                 vert_next[pos_x[RW-1:0]][pos_y];
    assign abs_wall[DIR_SOUTH] = (pos_y == '0) ? 1'b1 :
                                 horiz_next[y_south[RW-1:0]][pos_x];
    assign abs_wall[DIR_WEST]  = (pos_x == '0) ? 1'b1 :
                                 vert_next[x_west[RW-1:0]][pos_y];

    // Turn back into the mouse's frame.
    assign result.wall_left       = abs_wall[ctl.left_dir];
    assign result.wall_ahead      = abs_wall[ctl.front_dir];
    assign result.wall_right_side = abs_wall[ctl.right_dir];

endmodule

`default_nettype wire

@@ hdl/maze_wall_map.sv @@
// Wall map of a square maze of MAZE_DIM x MAZE_DIM cells, inner walls only, held in
// flip-flops. Each request item names a cell, an absolute heading and a command
// (record sensed walls, query, block the cell, clear the map) and returns one response
// item with the left, front and right walls of that cell after the command; border walls
// always read as set. The block takes one item per clock cycle unless the response
// stalls; each item is held in the input register, then the whole read-modify-write
// of the map and the read-back happen in one pass into the result register. A stalled
// response holds the result register and then the input register, so the request side
// waits only while both are full. After reset the map is empty except for the wall east
// of the start cell, and it can be used at once.
`default_nettype none

module maze_wall_map
    import mwm_pkg::*;
#(
    parameter int MAZE_DIM = MAZE_DIM_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    mwm_stream_if.sink          request,
    mwm_stream_if.source        response
);

    localparam int XW = $clog2(MAZE_DIM);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    in_item_t   s1_item_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_item_reg;
    logic       s1_adv;
    logic       in_take;
    wall_ctl_t  ctl;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] pos_y;
    out_item_t  rd_item;

    // Handshake: the input stage moves on when the result register is free or drains.
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || response.ready);
    assign request.ready = !s1_valid_reg || s1_adv;
    assign in_take       = request.valid && request.ready;

    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && !response.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= request.item;
        end
        if (s1_adv)
        begin
            out_item_reg <= rd_item;
        end
    end

    // Command decode.
    mwm_decode #(
        .MAZE_DIM (MAZE_DIM)
    ) u_decode (
        .item  (s1_item_reg),
        .ctl   (ctl),
        .pos_x (pos_x),
        .pos_y (pos_y)
    );

    // Wall map with read-back.
    mwm_wall_store #(
        .MAZE_DIM (MAZE_DIM)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (s1_adv),
        .ctl    (ctl),
        .pos_x  (pos_x),
        .pos_y  (pos_y),
        .result (rd_item)
    );

    assign response.valid = out_valid_reg;
    assign response.item  = out_item_reg;

    // Both stages full and the response stalled: no new item may enter.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !response.ready) |-> !request.ready)
        else $error("request accepted while both stages are full");

    // A blocked cell reports walls on every side.
    a_block_walls: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (command_t'(s1_item_reg.command) == CMD_BLOCK)) |=>
        (out_item_reg.wall_left && out_item_reg.wall_ahead &&
         out_item_reg.wall_right_side))
        else $error("blocked cell reports an open side");

    // A recorded front wall reads back as set.
    a_record_front: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (command_t'(s1_item_reg.command) == CMD_RECORD) &&
         s1_item_reg.sensed_front) |=> out_item_reg.wall_ahead)
        else $error("recorded front wall lost");

    // After a clear, the start cell facing north still has its east wall.
    a_clear_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && ctl.clear && (pos_x == '0) && (pos_y == '0) &&
         (ctl.front_dir == DIR_NORTH)) |=> out_item_reg.wall_right_side)
        else $error("start cell east wall missing after clear");

endmodule

`default_nettype wire
